/* rtl/dcbsp_pkg.sv */
// Package for the DC bus source protection block.
// Holds the command and tie mode codes, register indexes, field widths and the
// structs shared by the register file, the evaluation logic and the top level.
package dcbsp_pkg;

   // Field widths.
   localparam int NUM_CELLS   = 3;
   localparam int CUR_W       = 16;
   localparam int VOLT_W      = 15;
   localparam int LIMIT_W     = 15;
   localparam int SUM_W       = VOLT_W + 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 15;

   // The overcurrent limit after reset is 75.00 A.
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(7500);

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] REG_TIE_MODE  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_GROUND_EN = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] REG_OC_LIMIT  = CSR_INDEX_W'(2);

   typedef enum logic [1:0] {
      ACT_TICK       = 2'd0,
      ACT_CONNECT    = 2'd1,
      ACT_DISCONNECT = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      TIE_OFF    = 2'd0,
      TIE_AUTO   = 2'd1,
      TIE_ALWAYS = 2'd2
   } tie_mode_type;

   // Configuration seen by the evaluation logic.
   typedef struct packed {
      logic [1:0]         tie_mode;
      logic               ground_en;
      logic [LIMIT_W-1:0] oc_limit;
   } cfg_type;

   // One request transaction as held in the input register.
   typedef struct packed {
      logic [1:0]                          action;
      logic [1:0]                          cell_select;
      logic [NUM_CELLS-1:0][CUR_W-1:0]     cell_current;
      logic [NUM_CELLS-1:0][VOLT_W-1:0]    cell_voltage;
      logic [VOLT_W-1:0]                   battery1_voltage;
      logic [VOLT_W-1:0]                   battery2_voltage;
      logic [VOLT_W-1:0]                   ground_voltage;
      logic [VOLT_W-1:0]                   docked_voltage;
   } req_type;

   // Protection state carried from one transaction to the next.
   typedef struct packed {
      logic [NUM_CELLS-1:0] linked;
      logic [NUM_CELLS-1:0] alarm;
      logic                 tie;
   } state_type;

   // One response transaction as held in the result register.
   typedef struct packed {
      logic [NUM_CELLS-1:0] connected_mask;
      logic [NUM_CELLS-1:0] alarm_mask;
      logic                 any_alarm;
      logic                 batteries_tied;
      logic                 bus_live;
   } rsp_type;

endpackage

/* rtl/dcbsp_if.sv */
// Channel interfaces for the DC bus source protection block.
// Request, response and configuration write channels; widths come from dcbsp_pkg.

// Request channel: one command or protection tick per transaction.
interface dcbsp_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          action;
   logic [1:0]                          cell_select;
   logic signed [dcbsp_pkg::CUR_W-1:0]  cell1_current;
   logic signed [dcbsp_pkg::CUR_W-1:0]  cell2_current;
   logic signed [dcbsp_pkg::CUR_W-1:0]  cell3_current;
   logic signed [dcbsp_pkg::VOLT_W-1:0] cell1_voltage;
   logic signed [dcbsp_pkg::VOLT_W-1:0] cell2_voltage;
   logic signed [dcbsp_pkg::VOLT_W-1:0] cell3_voltage;
   logic signed [dcbsp_pkg::VOLT_W-1:0] battery1_voltage;
   logic signed [dcbsp_pkg::VOLT_W-1:0] battery2_voltage;
   logic signed [dcbsp_pkg::VOLT_W-1:0] ground_voltage;
   logic signed [dcbsp_pkg::VOLT_W-1:0] docked_voltage;

   modport source (
      output valid, action, cell_select, cell1_current, cell2_current, cell3_current,
             cell1_voltage, cell2_voltage, cell3_voltage, battery1_voltage,
             battery2_voltage, ground_voltage, docked_voltage,
      input  ready
   );
   modport sink (
      input  valid, action, cell_select, cell1_current, cell2_current, cell3_current,
             cell1_voltage, cell2_voltage, cell3_voltage, battery1_voltage,
             battery2_voltage, ground_voltage, docked_voltage,
      output ready
   );
endinterface

// Response channel: the state after each request transaction.
interface dcbsp_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [dcbsp_pkg::NUM_CELLS-1:0]    connected_mask;
   logic [dcbsp_pkg::NUM_CELLS-1:0]    alarm_mask;
   logic                               any_alarm;
   logic                               batteries_tied;
   logic                               bus_live;

   modport source (
      output valid, connected_mask, alarm_mask, any_alarm, batteries_tied, bus_live,
      input  ready
   );
   modport sink (
      input  valid, connected_mask, alarm_mask, any_alarm, batteries_tied, bus_live,
      output ready
   );
endinterface

// Configuration write channel.
interface dcbsp_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [dcbsp_pkg::CSR_INDEX_W-1:0]    index;
   logic [dcbsp_pkg::CSR_DATA_W-1:0]     wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

/* rtl/dc_bus_source_protection.sv */
// DC bus source protection. A request accepted at a clock edge sits in the input register, and its
// response goes into the result register after one pass, once that register is free or draining.
// Throughput is one transaction per cycle while responses are taken; a held response stalls the
// input register only once both registers are full. Reset is synchronous and active high: it
// empties both stages, disconnects all cells, clears all alarms, opens the battery tie and restores
// the registers. Depends on dcbsp_pkg, dcbsp_if, dcbsp_csr and dcbsp_eval.
module dc_bus_source_protection (
   input  logic         clock,
   input  logic         reset,
   dcbsp_req_if.sink    req_bus,
   dcbsp_rsp_if.source  rsp_bus,
   dcbsp_csr_if.sink    csr_bus
);

   dcbsp_pkg::cfg_type   cfg;
   dcbsp_pkg::req_type   req_ff,     req_in;
   dcbsp_pkg::state_type state_ff,   state_in;
   dcbsp_pkg::state_type next_state;
   dcbsp_pkg::rsp_type   rsp_ff,     rsp_in;
   logic                 req_valid_ff, req_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 bus_live;
   logic                 req_take;
   logic                 advance;

   dcbsp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   dcbsp_eval u_eval (
      .req        (req_ff),
      .cur_state  (state_ff),
      .cfg        (cfg),
      .next_state (next_state),
      .bus_live   (bus_live)
   );

   // Handshake: the input stage moves on whenever the result register is free or draining.
   assign advance       = req_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !req_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   // Input register capture.
   always_comb begin
      req_in                  = req_ff;
      req_in.action           = req_bus.action;
      req_in.cell_select      = req_bus.cell_select;
      req_in.cell_current[0]  = req_bus.cell1_current;
      req_in.cell_current[1]  = req_bus.cell2_current;
      req_in.cell_current[2]  = req_bus.cell3_current;
      req_in.cell_voltage[0]  = req_bus.cell1_voltage;
      req_in.cell_voltage[1]  = req_bus.cell2_voltage;
      req_in.cell_voltage[2]  = req_bus.cell3_voltage;
      req_in.battery1_voltage = req_bus.battery1_voltage;
      req_in.battery2_voltage = req_bus.battery2_voltage;
      req_in.ground_voltage   = req_bus.ground_voltage;
      req_in.docked_voltage   = req_bus.docked_voltage;

      if (req_take) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end
   end

   // State and result register update when a transaction leaves the input stage.
   always_comb begin
      state_in = state_ff;
      rsp_in   = rsp_ff;
      if (advance) begin
         state_in              = next_state;
         rsp_in.connected_mask = next_state.linked;
         rsp_in.alarm_mask     = next_state.alarm;
         rsp_in.any_alarm      = |next_state.alarm;
         rsp_in.batteries_tied = next_state.tie;
         rsp_in.bus_live       = bus_live;
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control and protection state.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.connected_mask = rsp_ff.connected_mask;
   assign rsp_bus.alarm_mask     = rsp_ff.alarm_mask;
   assign rsp_bus.any_alarm      = rsp_ff.any_alarm;
   assign rsp_bus.batteries_tied = rsp_ff.batteries_tied;
   assign rsp_bus.bus_live       = rsp_ff.bus_live;

endmodule

/* rtl/dcbsp_csr.sv */
// Configuration registers of the DC bus source protection block.
// Depends on dcbsp_pkg and dcbsp_csr_if; always ready, writes to unknown indexes are dropped.
module dcbsp_csr (
   input  logic               clock,
   input  logic               reset,
   dcbsp_csr_if.sink          csr_bus,
   output dcbsp_pkg::cfg_type cfg
);

   logic [1:0]                    tie_mode_ff,  tie_mode_in;
   logic                          ground_en_ff, ground_en_in;
   logic [dcbsp_pkg::LIMIT_W-1:0] oc_limit_ff,  oc_limit_in;
   logic                          wr_en;

   assign csr_bus.ready = 1'b1;
   assign wr_en         = csr_bus.valid;

   // Register write decode.
   always_comb begin
      tie_mode_in  = tie_mode_ff;
      ground_en_in = ground_en_ff;
      oc_limit_in  = oc_limit_ff;
      if (wr_en) begin
         unique case (csr_bus.index)
            dcbsp_pkg::REG_TIE_MODE:  tie_mode_in  = csr_bus.wdata[1:0];
            dcbsp_pkg::REG_GROUND_EN: ground_en_in = csr_bus.wdata[0];
            dcbsp_pkg::REG_OC_LIMIT:  oc_limit_in  = csr_bus.wdata[dcbsp_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tie_mode_ff  <= dcbsp_pkg::TIE_OFF;
         ground_en_ff <= 1'b0;
         oc_limit_ff  <= dcbsp_pkg::LIMIT_RESET;
      end else begin
         tie_mode_ff  <= tie_mode_in;
         ground_en_ff <= ground_en_in;
         oc_limit_ff  <= oc_limit_in;
      end
   end

   assign cfg.tie_mode  = tie_mode_ff;
   assign cfg.ground_en = ground_en_ff;
   assign cfg.oc_limit  = oc_limit_ff;

endmodule

/* rtl/dcbsp_eval.sv */
// Next-state evaluation for the DC bus source protection block.
// Depends on dcbsp_pkg; purely combinational, sits between the input and result registers.
module dcbsp_eval (
   input  dcbsp_pkg::req_type   req,
   input  dcbsp_pkg::state_type cur_state,
   input  dcbsp_pkg::cfg_type   cfg,
   output dcbsp_pkg::state_type next_state,
   output logic                 bus_live
);

   localparam int SW = dcbsp_pkg::SUM_W;
   localparam int NC = dcbsp_pkg::NUM_CELLS;

   logic [NC-1:0]          over_cur;
   logic [NC-1:0]          under_volt;
   logic [NC-1:0]          linked_oc;
   logic [NC-1:0]          linked_uv;
   logic [NC-1:0]          sel_hot;
   logic signed [SW-1:0]   sum_oc;
   logic signed [SW-1:0]   sum_uv;
   logic signed [dcbsp_pkg::VOLT_W:0] batt_sum;
   logic                   gnd_pos;
   logic                   live;
   logic                   tie_next;

   // Overcurrent trip, then the linked cell sum and the other sources that decide whether the bus is live.
   always_comb begin
      for (int i = 0; i < NC; i++) begin
         over_cur[i] = cur_state.linked[i] &&
            ($signed(req.cell_current[i]) >
             $signed({2'b00, cfg.oc_limit}));
      end
      linked_oc = cur_state.linked & ~over_cur;

      sum_oc = '0;
      for (int i = 0; i < NC; i++) begin
         if (linked_oc[i]) begin
            sum_oc = sum_oc + SW'($signed(req.cell_voltage[i]));
         end
      end

      batt_sum = (dcbsp_pkg::VOLT_W+1)'($signed(req.battery1_voltage)) +
                 (dcbsp_pkg::VOLT_W+1)'($signed(req.battery2_voltage));
      gnd_pos  = cfg.ground_en && ($signed(req.ground_voltage) > 0);

      live = (sum_oc != '0) ||
             (cur_state.tie && (batt_sum != '0)) ||
             (cfg.ground_en && (req.ground_voltage != '0)) ||
             (req.docked_voltage != '0);
   end

   // Undervoltage trip on a live bus, then the sum left for the automatic tie.
   always_comb begin
      for (int i = 0; i < NC; i++) begin
         under_volt[i] = live && linked_oc[i] && ($signed(req.cell_voltage[i]) <= 0);
      end
      linked_uv = linked_oc & ~under_volt;

      sum_uv = '0;
      for (int i = 0; i < NC; i++) begin
         if (linked_uv[i]) begin
            sum_uv = sum_uv + SW'($signed(req.cell_voltage[i]));
         end
      end

      case (cfg.tie_mode)
         dcbsp_pkg::TIE_ALWAYS: tie_next = 1'b1;
         dcbsp_pkg::TIE_AUTO:   tie_next = !((sum_uv > 0) || gnd_pos);
         default:               tie_next = 1'b0;
      endcase
   end

   // One-hot form of the cell named by a command; cell zero names nothing.
   always_comb begin
      unique case (req.cell_select)
         2'd1:    sel_hot = 3'b001;
         2'd2:    sel_hot = 3'b010;
         2'd3:    sel_hot = 3'b100;
         default: sel_hot = 3'b000;
      endcase
   end

   // Pick the update for this transaction's action.
   always_comb begin
      next_state = cur_state;
      bus_live   = 1'b0;
      unique case (req.action)
         dcbsp_pkg::ACT_TICK: begin
            next_state.linked = linked_uv;
            next_state.alarm  = cur_state.alarm | over_cur | under_volt;
            next_state.tie    = tie_next;
            bus_live          = live;
         end
         dcbsp_pkg::ACT_CONNECT: begin
            next_state.linked = cur_state.linked | sel_hot;
            next_state.alarm  = cur_state.alarm & ~sel_hot;
         end
         dcbsp_pkg::ACT_DISCONNECT: begin
            next_state.linked = cur_state.linked & ~sel_hot;
            next_state.alarm  = cur_state.alarm & ~sel_hot;
         end
         default: ;
      endcase
   end

endmodule

/* rtl/dcbsp_chk.sv */
// Port-level checker for the DC bus source protection block, bound to the top level.
// Depends on dcbsp_pkg for widths; observes the response channel only.
module dcbsp_chk (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [dcbsp_pkg::NUM_CELLS-1:0] connected_mask,
   input logic [dcbsp_pkg::NUM_CELLS-1:0] alarm_mask,
   input logic                            any_alarm
);

   // A reset always empties the result register.
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid in the cycle after reset");

   // A cell only latches an alarm as it is dropped, and linking clears it.
   a_link_alarm_disjoint: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((connected_mask & alarm_mask) == '0))
      else $error("cell shown both connected and in alarm");

   // The summary alarm follows the alarm mask.
   a_any_alarm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (any_alarm == (|alarm_mask)))
      else $error("any_alarm disagrees with alarm_mask");

   // A stalled response keeps its masks.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(connected_mask) && $stable(alarm_mask)))
      else $error("stalled response changed");

endmodule

bind dc_bus_source_protection dcbsp_chk u_chk (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .connected_mask (rsp_bus.connected_mask),
   .alarm_mask     (rsp_bus.alarm_mask),
   .any_alarm      (rsp_bus.any_alarm)
);

/* sim/dcbsp_checker.sv */
// Checker for the DC bus source protection block: watches the request, response and
// configuration channels, predicts each response and compares it field by field.
// Depends on dcbsp_pkg and the channel interfaces in dcbsp_if.
module dcbsp_checker (
   input  logic        clock,
   input  logic        reset,
   dcbsp_req_if        req_bus,
   dcbsp_rsp_if        rsp_bus,
   dcbsp_csr_if        csr_bus,
   output int          failures,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import dcbsp_pkg::*;

   // Shadow copy of the configuration registers.
   logic [1:0]           tie_mode_q;
   logic                 ground_en_q;
   logic [LIMIT_W-1:0]   oc_limit_q;

   // Shadow copy of the protection state.
   logic [NUM_CELLS-1:0] linked_q;
   logic [NUM_CELLS-1:0] alarm_q;
   logic                 tie_q;

   // Predicted bus status, oldest first.
   rsp_type expected_status_q[$];

   // Sum of the voltages of the cells that are linked at the moment.
   function automatic int linked_voltage_sum(input int volt [NUM_CELLS]);
      int sum;
      sum = 0;
      for (int i = 0; i < NUM_CELLS; i++) begin
         if (linked_q[i]) sum += volt[i];
      end
      return sum;
   endfunction

   // Applies one request transaction to the shadow state and returns the bus status after it.
   function automatic rsp_type protect_step(input req_type r);
      int                   cur [NUM_CELLS];
      int                   volt [NUM_CELLS];
      int                   battery_sum;
      int                   gnd;
      int                   dock;
      logic                 live;
      logic                 tie;
      logic [NUM_CELLS-1:0] sel_bit;
      rsp_type              status;
      live = 1'b0;
      for (int i = 0; i < NUM_CELLS; i++) begin
         cur[i]  = $signed(r.cell_current[i]);
         volt[i] = $signed(r.cell_voltage[i]);
      end
      if (r.action == ACT_CONNECT || r.action == ACT_DISCONNECT) begin
         // A command that names cell zero leaves everything as it was.
         if (r.cell_select != 2'd0) begin
            sel_bit = NUM_CELLS'(1) << (r.cell_select - 2'd1);
            if (r.action == ACT_CONNECT) linked_q |= sel_bit;
            else linked_q &= ~sel_bit;
            alarm_q &= ~sel_bit;
         end
      end else if (r.action == ACT_TICK) begin
         battery_sum = int'($signed(r.battery1_voltage)) + int'($signed(r.battery2_voltage));
         gnd         = $signed(r.ground_voltage);
         dock        = $signed(r.docked_voltage);
         // Overcurrent trips come first; a current equal to the limit is still fine.
         for (int i = 0; i < NUM_CELLS; i++) begin
            if (linked_q[i] && cur[i] > int'(oc_limit_q)) begin
               linked_q[i] = 1'b0;
               alarm_q[i]  = 1'b1;
            end
         end
         // The battery pair only counts if it was tied before this tick.
         live = (linked_voltage_sum(volt) != 0) || (tie_q && battery_sum != 0) ||
                (ground_en_q && gnd != 0) || (dock != 0);
         // On a live bus a linked cell at or below zero volts is dropped.
         if (live) begin
            for (int i = 0; i < NUM_CELLS; i++) begin
               if (linked_q[i] && volt[i] <= 0) begin
                  linked_q[i] = 1'b0;
                  alarm_q[i]  = 1'b1;
               end
            end
         end
         // The unused tie mode code behaves as off.
         case (tie_mode_q)
            TIE_ALWAYS: tie = 1'b1;
            TIE_AUTO:   tie = !(linked_voltage_sum(volt) > 0 || (ground_en_q && gnd > 0));
            default:    tie = 1'b0;
         endcase
         tie_q = tie;
      end
      status.connected_mask = linked_q;
      status.alarm_mask     = alarm_q;
      status.any_alarm      = |alarm_q;
      status.batteries_tied = tie_q;
      status.bus_live       = live;
      return status;
   endfunction

   // Reports one field that differs from its prediction.
   function automatic void check_field(input string name, input logic [2:0] want,
                                       input logic [2:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endfunction

   // Register writes, then request prediction, then response comparison, all at the edge.
   always @(posedge clock) begin : monitor
      req_type sampled;
      rsp_type expected;
      if (reset) begin
         tie_mode_q  = TIE_OFF;
         ground_en_q = 1'b0;
         oc_limit_q  = LIMIT_RESET;
         linked_q    = '0;
         alarm_q     = '0;
         tie_q       = 1'b0;
         failures    = 0;
         expected_status_q.delete();
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            // Writes to an index beyond the list are ignored; values are masked to width.
            case (csr_bus.index)
               REG_TIE_MODE:  tie_mode_q  = csr_bus.wdata[1:0];
               REG_GROUND_EN: ground_en_q = csr_bus.wdata[0];
               REG_OC_LIMIT:  oc_limit_q  = csr_bus.wdata[LIMIT_W-1:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            sampled.action           = req_bus.action;
            sampled.cell_select      = req_bus.cell_select;
            sampled.cell_current[0]  = req_bus.cell1_current;
            sampled.cell_current[1]  = req_bus.cell2_current;
            sampled.cell_current[2]  = req_bus.cell3_current;
            sampled.cell_voltage[0]  = req_bus.cell1_voltage;
            sampled.cell_voltage[1]  = req_bus.cell2_voltage;
            sampled.cell_voltage[2]  = req_bus.cell3_voltage;
            sampled.battery1_voltage = req_bus.battery1_voltage;
            sampled.battery2_voltage = req_bus.battery2_voltage;
            sampled.ground_voltage   = req_bus.ground_voltage;
            sampled.docked_voltage   = req_bus.docked_voltage;
            expected_status_q.push_back(protect_step(sampled));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_status_q.size() == 0) begin
               $error("response transaction with no request waiting: connected_mask %0d",
                      rsp_bus.connected_mask);
               failures++;
            end else begin
               expected = expected_status_q.pop_front();
               check_field("connected_mask", expected.connected_mask, rsp_bus.connected_mask);
               check_field("alarm_mask", expected.alarm_mask, rsp_bus.alarm_mask);
               check_field("any_alarm", expected.any_alarm, rsp_bus.any_alarm);
               check_field("batteries_tied", expected.batteries_tied, rsp_bus.batteries_tied);
               check_field("bus_live", expected.bus_live, rsp_bus.bus_live);
            end
         end
      end
      outstanding = expected_status_q.size();
   end

endmodule

/* sim/dc_bus_source_protection_test.sv */
// Top of the DC bus source protection testbench: clock, reset, stimulus and verdict.
// Instantiates the block beside dcbsp_checker; depends on dcbsp_pkg and dcbsp_if.
module dc_bus_source_protection_test;
   timeunit 1ns;
   timeprecision 1ps;
   import dcbsp_pkg::*;

   // Codes that the fields allow but the package does not name.
   localparam logic [1:0]             ACT_UNUSED = 2'd3;
   localparam logic [1:0]             TIE_UNUSED = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 2'd3;

   localparam int STALL_LIMIT     = 5000;
   localparam int HOLD_CYCLES     = 200;
   localparam int ITEMS_PER_PHASE = 100;

   logic clock = 1'b0;
   logic reset;

   dcbsp_req_if req_bus ();
   dcbsp_rsp_if rsp_bus ();
   dcbsp_csr_if csr_bus ();

   int                 failures;
   int                 outstanding;
   int                 send_idle_pct = 0;
   int                 rsp_idle_pct  = 0;
   int                 hold_requests = 0;
   int                 requests_sent = 0;
   int                 writes_done   = 0;
   int                 idle_cycles   = 0;
   logic [LIMIT_W-1:0] limit_now;

   always #10 clock = ~clock;

   dc_bus_source_protection u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   dcbsp_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_bus     (csr_bus),
      .failures    (failures),
      .outstanding (outstanding)
   );

   // Watchdog: ends the run when no transaction moves on any channel for too long.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Response side: random back-pressure, plus long hold-offs on request.
   initial begin : receiver
      int hold_served;
      int hold_left;
      hold_served   = 0;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests > hold_served) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
         end
         if (reset) begin
            rsp_bus.ready = 1'b0;
         end else if (hold_left > 0) begin
            rsp_bus.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready = ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Cell voltages: mostly healthy, some at zero, some negative, some anywhere.
   function automatic logic [VOLT_W-1:0] random_voltage();
      int pick;
      int v;
      pick = $urandom_range(99);
      if (pick < 70) v = $urandom_range(10000, 1);
      else if (pick < 80) v = 0;
      else if (pick < 90) v = -int'($urandom_range(10000, 1));
      else v = $urandom;
      return VOLT_W'(v);
   endfunction

   // Battery, ground and docked supplies: often absent.
   function automatic logic [VOLT_W-1:0] random_source();
      int pick;
      int v;
      pick = $urandom_range(99);
      if (pick < 50) v = 0;
      else if (pick < 80) v = $urandom_range(10000, 1);
      else v = $urandom;
      return VOLT_W'(v);
   endfunction

   // Cell currents: mostly within the present limit, some just above it, some anywhere.
   function automatic logic [CUR_W-1:0] random_current();
      int pick;
      int lim;
      int v;
      lim  = int'(limit_now);
      pick = $urandom_range(99);
      if (pick < 70) v = int'($urandom_range(2 * lim, 0)) - lim;
      else if (pick < 85 && lim < 32767)
         v = lim + int'($urandom_range((lim < 27767) ? 5000 : 32767 - lim, 1));
      else v = $urandom;
      return CUR_W'(v);
   endfunction

   // Mostly ticks, with enough connect commands to keep cells on the bus.
   function automatic req_type random_request();
      req_type it;
      int      pick;
      pick           = $urandom_range(99);
      it.action      = ACT_TICK;
      it.cell_select = 2'($urandom_range(3, 1));
      if (pick < 15) it.action = ACT_CONNECT;
      else if (pick < 22) it.action = ACT_DISCONNECT;
      else if (pick < 24) it.action = ACT_UNUSED;
      if ($urandom_range(19) == 0) it.cell_select = 2'd0;
      for (int i = 0; i < NUM_CELLS; i++) begin
         it.cell_current[i] = random_current();
         it.cell_voltage[i] = random_voltage();
      end
      it.battery1_voltage = random_source();
      // Now and then the two batteries cancel out exactly.
      it.battery2_voltage = ($urandom_range(9) == 0) ? -it.battery1_voltage : random_source();
      it.ground_voltage   = random_source();
      it.docked_voltage   = random_source();
      return it;
   endfunction

   function automatic req_type command(input logic [1:0] act, input logic [1:0] sel);
      req_type it;
      it             = random_request();
      it.action      = act;
      it.cell_select = sel;
      return it;
   endfunction

   // A tick with every measurement at zero; directed cases set what they need.
   function automatic req_type quiet_tick();
      req_type it;
      it             = '0;
      it.action      = ACT_TICK;
      it.cell_select = 2'd1;
      return it;
   endfunction

   task automatic drive_fields(input req_type it);
      req_bus.action           = it.action;
      req_bus.cell_select      = it.cell_select;
      req_bus.cell1_current    = it.cell_current[0];
      req_bus.cell2_current    = it.cell_current[1];
      req_bus.cell3_current    = it.cell_current[2];
      req_bus.cell1_voltage    = it.cell_voltage[0];
      req_bus.cell2_voltage    = it.cell_voltage[1];
      req_bus.cell3_voltage    = it.cell_voltage[2];
      req_bus.battery1_voltage = it.battery1_voltage;
      req_bus.battery2_voltage = it.battery2_voltage;
      req_bus.ground_voltage   = it.ground_voltage;
      req_bus.docked_voltage   = it.docked_voltage;
   endtask

   // Offers one request transaction after a random gap and waits for it to be taken.
   task automatic send_request(input req_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      drive_fields(it);
      req_bus.valid = 1'b1;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      @(negedge clock);
      requests_sent++;
   endtask

   // Stops offering requests until every predicted response has come back.
   task automatic drain_results();
      req_bus.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Register writes only happen once the block has gone quiet.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] reg_index,
                            input logic [CSR_DATA_W-1:0] data);
      drain_results();
      csr_bus.index = reg_index;
      csr_bus.wdata = data;
      csr_bus.valid = 1'b1;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      @(negedge clock);
      csr_bus.valid = 1'b0;
      writes_done++;
   endtask

   task automatic set_limit(input logic [LIMIT_W-1:0] lim);
      write_reg(REG_OC_LIMIT, CSR_DATA_W'(lim));
      limit_now = lim;
   endtask

   initial begin : stimulus
      req_type it;
      int      phase;
      // Every input known from time zero with reset held, then reset released.
      reset         = 1'b1;
      limit_now     = LIMIT_RESET;
      req_bus.valid = 1'b0;
      drive_fields(quiet_tick());
      csr_bus.valid = 1'b0;
      csr_bus.index = REG_TIE_MODE;
      csr_bus.wdata = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part with the registers as they come out of reset.
      send_request(quiet_tick());
      send_request(command(ACT_CONNECT, 2'd1));
      send_request(command(ACT_CONNECT, 2'd2));
      send_request(command(ACT_CONNECT, 2'd3));
      send_request(command(ACT_CONNECT, 2'd0));
      send_request(command(ACT_UNUSED, 2'd2));
      // Currents at the limit and at the negative extreme do not trip.
      it                 = quiet_tick();
      it.cell_voltage    = {3{VOLT_W'(500)}};
      it.cell_current[0] = CUR_W'(7500);
      it.cell_current[1] = CUR_W'(100);
      it.cell_current[2] = CUR_W'(-32768);
      send_request(it);
      // One hundredth above the limit trips cell one.
      it.cell_current[0] = CUR_W'(7501);
      send_request(it);
      // A live bus drops the cell sitting at zero volts.
      it                 = quiet_tick();
      it.cell_voltage[2] = VOLT_W'(400);
      send_request(it);
      send_request(command(ACT_DISCONNECT, 2'd1));
      send_request(command(ACT_CONNECT, 2'd2));
      // A dead bus leaves cells at zero volts linked.
      send_request(quiet_tick());
      // Extreme values on the currents, the cell voltages and the docked voltage.
      it                 = quiet_tick();
      it.cell_current[0] = CUR_W'(32767);
      it.cell_current[1] = CUR_W'(-32768);
      it.cell_voltage[1] = VOLT_W'(-16384);
      it.cell_voltage[2] = VOLT_W'(16383);
      it.docked_voltage  = VOLT_W'(-16384);
      send_request(it);
      send_request(command(ACT_DISCONNECT, 2'd3));
      send_request(command(ACT_DISCONNECT, 2'd0));

      // Automatic tie with ground power wired in.
      write_reg(REG_TIE_MODE, CSR_DATA_W'(TIE_AUTO));
      write_reg(REG_GROUND_EN, CSR_DATA_W'(1));
      send_request(command(ACT_CONNECT, 2'd1));
      send_request(quiet_tick());
      // Tied batteries that cancel out do not make the bus live.
      it                  = quiet_tick();
      it.battery1_voltage = VOLT_W'(1000);
      it.battery2_voltage = VOLT_W'(-1000);
      send_request(it);
      it.battery2_voltage = VOLT_W'(200);
      send_request(it);
      // Positive ground power opens the tie.
      it                = quiet_tick();
      it.ground_voltage = VOLT_W'(2000);
      send_request(it);

      // Tie always closed and a zero current limit.
      write_reg(REG_TIE_MODE, CSR_DATA_W'(TIE_ALWAYS));
      set_limit('0);
      send_request(command(ACT_CONNECT, 2'd1));
      it                 = quiet_tick();
      it.cell_current[0] = CUR_W'(1);
      it.docked_voltage  = VOLT_W'(100);
      send_request(it);
      send_request(command(ACT_CONNECT, 2'd1));
      it                 = quiet_tick();
      it.cell_voltage[0] = VOLT_W'(5000);
      send_request(it);

      // Random part: six register settings over three idling patterns.
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_reg(REG_TIE_MODE, {13'($urandom), TIE_OFF});
               write_reg(REG_GROUND_EN, {14'($urandom), 1'b0});
               set_limit('0);
            end
            1: begin
               write_reg(REG_TIE_MODE, {13'($urandom), TIE_AUTO});
               write_reg(REG_GROUND_EN, {14'($urandom), 1'b1});
               write_reg(REG_UNUSED, CSR_DATA_W'($urandom));
               set_limit('1);
            end
            2: begin
               write_reg(REG_TIE_MODE, CSR_DATA_W'(TIE_ALWAYS));
               write_reg(REG_GROUND_EN, CSR_DATA_W'(0));
               set_limit(LIMIT_RESET);
            end
            3: begin
               write_reg(REG_TIE_MODE, {13'($urandom), TIE_UNUSED});
               write_reg(REG_GROUND_EN, CSR_DATA_W'(1));
               set_limit(LIMIT_W'($urandom_range(30000, 0)));
            end
            4: begin
               write_reg(REG_TIE_MODE, CSR_DATA_W'(TIE_AUTO));
               write_reg(REG_GROUND_EN, CSR_DATA_W'(0));
               set_limit(LIMIT_W'(30000));
            end
            default: begin
               write_reg(REG_TIE_MODE, CSR_DATA_W'(TIE_ALWAYS));
               write_reg(REG_GROUND_EN, CSR_DATA_W'(1));
               set_limit(LIMIT_W'($urandom_range(30000, 0)));
            end
         endcase
         if (phase < 2) begin
            send_idle_pct = 32;
            rsp_idle_pct  = 77;
         end else if (phase < 4) begin
            send_idle_pct = 77;
            rsp_idle_pct  = 32;
         end else begin
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // A long response hold-off while requests keep coming fills the block up.
            if ((phase == 0 || phase == 4) && n == 40) hold_requests++;
            send_request(random_request());
         end
         drain_results();
      end

      // Tail: let any late response show up before the verdict.
      repeat (6) @(negedge clock);
      $display("Sent %0d request transactions and %0d register writes under three idling",
               requests_sent, writes_done);
      $display("patterns, covering every tie mode code, ground on and off and limit extremes.");
      if (failures == 0 && outstanding == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
